// ===== rtl/core/tpfk_pkg.sv =====
`timescale 1ns / 1ps
package tpfk_pkg;

  // item operation codes
  localparam logic [2:0] OP_POLL     = 3'd0;
  localparam logic [2:0] OP_TIMEOUT  = 3'd1;
  localparam logic [2:0] OP_RESPONSE = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_INIT     = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TBYTE   = 2'd2;

  // configuration register map
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_ERROR_FILL = 2'd0;
  localparam logic [1:0] REG_INIT_FILL  = 2'd1;
  localparam logic [1:0] REG_MISS_LIMIT = 2'd2;

  // bytes kept per remote block, one memory row each
  localparam int unsigned ROW_BYTES = 4;

  // write controls from the sequencer to the store
  typedef struct packed {
    logic tbl_we;   // write one table row
    logic miss_we;  // write one miss count
    logic init;     // whole table to the init byte
  } tpfk_wr_t;

  // one nibble to one table byte: set bit gives 00, clear bit gives 11
  function automatic logic [7:0] expand_nibble(input logic [3:0] nib);
    logic [7:0] res;
    res[7:6] = {2{~nib[0]}};
    res[5:4] = {2{~nib[1]}};
    res[3:2] = {2{~nib[2]}};
    res[1:0] = {2{~nib[3]}};
    return res;
  endfunction

endpackage

// ===== rtl/core/tpfk_if.sv =====
`timescale 1ns / 1ps
// input item channel
interface tpfk_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] block_id;
  logic [7:0] byte_first;
  logic [7:0] byte_second;

  modport source (output valid, op, block_id, byte_first, byte_second, input ready);
  modport sink   (input valid, op, block_id, byte_first, byte_second, output ready);
endinterface

// result item channel
interface tpfk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] block_code;
  logic [7:0] data_byte;
  logic [3:0] byte_index;
  logic       last;

  modport source (output valid, kind, block_code, data_byte, byte_index, last, input ready);
  modport sink   (input valid, kind, block_code, data_byte, byte_index, last, output ready);
endinterface

// ===== rtl/core/telemetry_poll_frame_keeper.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake         | payload
// in_ch     | in  | valid / ready     | op, block_id, byte_first, byte_second
// out_ch    | out | valid / ready     | kind, block_code, data_byte, byte_index, last
// apb       | in  | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// a poll, timeout, response or init item is accepted with the memory read of
// the cursor row, then modified and written back with the result
// a read item sends one table byte per cycle from the row memory while the
// output is not held, one row read every four bytes
// reset needs no clearing pass: per-row live bits make unwritten rows read
// as zero (or as the init byte after an init item)
// a result waiting in the output register holds the execute and read steps
module telemetry_poll_frame_keeper
  import tpfk_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  tpfk_in_if.sink            in_ch,
  tpfk_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned TABLE_BYTES = ROW_BYTES * NUM_BLOCKS;
  localparam int unsigned IW = $clog2(TABLE_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  // configuration registers
  logic [7:0] error_fill_r;
  logic [7:0] init_fill_r;
  logic [3:0] miss_limit_r;

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic          ready_r, ready_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  // latched item
  logic [2:0] op_r;
  logic [7:0] bid_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [1:0] out_code_r, out_code_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic [3:0] out_index_r, out_index_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_load;
  logic       out_free;

  // store connections
  logic                   rd_en;
  logic [CW-1:0]          rd_addr;
  logic [8*ROW_BYTES-1:0] rd_row;
  logic [4:0]             rd_miss;
  tpfk_wr_t               wr;
  logic [8*ROW_BYTES-1:0] wr_row;
  logic [4:0]             wr_miss;

  logic in_acc;
  logic cfg_wr;

  tpfk_store #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_row    (rd_row),
    .rd_miss   (rd_miss),
    .wr        (wr),
    .wr_addr   (cursor_r),
    .wr_row    (wr_row),
    .wr_miss   (wr_miss),
    .init_byte (init_fill_r)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_fill_r <= 8'd0;
      init_fill_r  <= 8'd0;
      miss_limit_r <= 4'd3;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ERROR_FILL: error_fill_r <= pwdata[7:0];
        REG_INIT_FILL:  init_fill_r  <= pwdata[7:0];
        REG_MISS_LIMIT: miss_limit_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ERROR_FILL: prdata = 32'(error_fill_r);
      REG_INIT_FILL:  prdata = 32'(init_fill_r);
      REG_MISS_LIMIT: prdata = 32'(miss_limit_r);
      default:        prdata = 32'd0;
    endcase
  end

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // sequencer: read, modify, write back
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    ready_nxt     = ready_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    rd_addr       = cursor_r;
    wr            = '0;
    wr_row        = {ROW_BYTES{error_fill_r}};
    wr_miss       = 5'd0;
    out_load      = 1'b0;
    out_kind_nxt  = KIND_ACK;
    out_code_nxt  = 2'd0;
    out_data_nxt  = 8'd0;
    out_index_nxt = 4'd0;
    out_last_nxt  = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_en = 1'b1;
          if (in_ch.op == OP_READ) begin
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = S_DUMP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_POLL: begin
              if (ready_r) begin
                ready_nxt    = 1'b0;
                cursor_nxt   = (cursor_r == CW'(NUM_BLOCKS - 1)) ? '0 : cursor_r + 1'b1;
                out_kind_nxt = KIND_REQUEST;
                out_code_nxt = 2'(cursor_nxt);
              end
            end
            OP_TIMEOUT: begin
              ready_nxt = 1'b1;
              if (rd_miss > {1'b0, miss_limit_r}) begin
                wr.tbl_we = 1'b1;
                wr_row    = {ROW_BYTES{error_fill_r}};
              end else begin
                wr.miss_we = 1'b1;
                wr_miss    = rd_miss + 5'd1;
              end
            end
            OP_RESPONSE: begin
              if (bid_r < 8'(NUM_BLOCKS)) begin
                ready_nxt  = 1'b1;
                wr.tbl_we  = 1'b1;
                wr.miss_we = 1'b1;
                wr_miss    = 5'd0;
                wr_row     = {expand_nibble(b2_r[3:0]), expand_nibble(b2_r[7:4]),
                              expand_nibble(b1_r[3:0]), expand_nibble(b1_r[7:4])};
              end
            end
            OP_INIT: begin
              wr.init = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_TBYTE;
          out_data_nxt  = rd_row[{idx_r[1:0], 3'b000} +: 8];
          out_index_nxt = 4'(idx_r);
          out_last_nxt  = (idx_r == IW'(TABLE_BYTES - 1));
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            // fetch the next row while the last byte of this one goes out
            if (idx_r[1:0] == 2'd3) begin
              rd_en   = 1'b1;
              rd_addr = idx_r[IW-1:2] + 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      ready_r     <= 1'b1;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      ready_r  <= ready_nxt;
      idx_r    <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.op;
      bid_r <= in_ch.block_id;
      b1_r  <= in_ch.byte_first;
      b2_r  <= in_ch.byte_second;
    end
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_code_r  <= out_code_nxt;
      out_data_r  <= out_data_nxt;
      out_index_r <= out_index_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.block_code = out_code_r;
  assign out_ch.data_byte  = out_data_r;
  assign out_ch.byte_index = out_index_r;
  assign out_ch.last       = out_last_r;

endmodule

// ===== rtl/core/tpfk_store.sv =====
`timescale 1ns / 1ps
module tpfk_store
  import tpfk_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 4,
  localparam int unsigned CW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // read port, registered data
  input  logic                    rd_en,
  input  logic [CW-1:0]           rd_addr,
  output logic [8*ROW_BYTES-1:0]  rd_row,
  output logic [4:0]              rd_miss,
  // write port
  input  tpfk_wr_t                wr,
  input  logic [CW-1:0]           wr_addr,
  input  logic [8*ROW_BYTES-1:0]  wr_row,
  input  logic [4:0]              wr_miss,
  input  logic [7:0]              init_byte
);

  logic [8*ROW_BYTES-1:0] tbl_mem [NUM_BLOCKS];
  logic [4:0]             miss_mem [NUM_BLOCKS];

  logic [NUM_BLOCKS-1:0]  tbl_live_r;
  logic [NUM_BLOCKS-1:0]  miss_live_r;
  logic [7:0]             dflt_r;

  logic [8*ROW_BYTES-1:0] rd_row_r;
  logic [4:0]             rd_miss_r;
  logic                   rd_tlive_r;
  logic                   rd_mlive_r;

  // memory writes
  always_ff @(posedge clk) begin
    if (wr.tbl_we) begin
      tbl_mem[wr_addr] <= wr_row;
    end
    if (wr.miss_we) begin
      miss_mem[wr_addr] <= wr_miss;
    end
  end

  // registered memory reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r  <= tbl_mem[rd_addr];
      rd_miss_r <= miss_mem[rd_addr];
    end
  end

  // live bits: a table row not yet written reads as the default byte, a miss count as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_live_r  <= '0;
      miss_live_r <= '0;
      dflt_r      <= 8'd0;
      rd_tlive_r  <= 1'b0;
      rd_mlive_r  <= 1'b0;
    end else begin
      if (wr.init) begin
        tbl_live_r <= '0;
        dflt_r     <= init_byte;
      end else if (wr.tbl_we) begin
        tbl_live_r[wr_addr] <= 1'b1;
      end
      if (wr.miss_we) begin
        miss_live_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_tlive_r <= tbl_live_r[rd_addr];
        rd_mlive_r <= miss_live_r[rd_addr];
      end
    end
  end

  assign rd_row  = rd_tlive_r ? rd_row_r : {ROW_BYTES{dflt_r}};
  assign rd_miss = rd_mlive_r ? rd_miss_r : 5'd0;

endmodule

// ===== tb/sv/tb_telemetry_poll_frame_keeper.sv =====
`timescale 1ns / 1ps
module tb_telemetry_poll_frame_keeper;
  import tpfk_pkg::*;

  localparam int TB_BLOCKS      = 4;
  localparam int TABLE_LEN      = ROW_BYTES * TB_BLOCKS;
  localparam int SETTLE_CYCLES  = 2 * TABLE_LEN + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // op codes outside the defined set, answered by the block with a plain ack
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] block_id;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
  } poll_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] code;
    logic [7:0] data;
    logic [3:0] idx;
    logic       last;
  } frame_res_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  tpfk_in_if  in_ch ();
  tpfk_out_if out_ch ();

  telemetry_poll_frame_keeper #(.NUM_BLOCKS(TB_BLOCKS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // predicted block state and configuration
  logic [1:0] m_cursor;
  logic       m_ready;
  logic [4:0] m_miss [TB_BLOCKS];
  logic [7:0] m_table [TABLE_LEN];
  logic [7:0] m_err_fill;
  logic [7:0] m_init_fill;
  logic [3:0] m_limit;

  poll_cmd_t  pending [$];
  frame_res_t frame_expect [$];
  poll_cmd_t  on_wire;

  idle_mode_t idle_mode = IDLE_NONE;
  int         hold_token = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         stall_cycles = 0;

  int err_count = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_reads = 0;
  int n_fills = 0;
  int n_bad_ids = 0;
  int n_queued = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [7:0] nibble_to_pairs(input logic [3:0] nib);
    logic [7:0] res;
    for (int b = 0; b < 4; b++) res[7-2*b -: 2] = nib[b] ? 2'b00 : 2'b11;
    return res;
  endfunction

  // reset values of the predicted state
  task automatic keeper_reset();
    m_cursor = '0;
    m_ready = 1'b1;
    for (int i = 0; i < TB_BLOCKS; i++) m_miss[i] = '0;
    for (int i = 0; i < TABLE_LEN; i++) m_table[i] = '0;
    m_err_fill = '0;
    m_init_fill = '0;
    m_limit = 4'd3;
  endtask

  // update the predicted state for one accepted item, queue its results
  task automatic keeper_step(input poll_cmd_t c);
    frame_res_t r;
    int base;
    r = '{kind: KIND_ACK, code: 2'd0, data: 8'd0, idx: 4'd0, last: 1'b1};
    base = int'(m_cursor) * ROW_BYTES;
    case (c.op)
      OP_POLL: begin
        if (m_ready) begin
          m_ready = 1'b0;
          m_cursor = 2'((int'(m_cursor) + 1) % TB_BLOCKS);
          r.kind = KIND_REQUEST;
          r.code = m_cursor;
        end
      end
      OP_TIMEOUT: begin
        if (m_miss[m_cursor] > {1'b0, m_limit}) begin
          for (int i = 0; i < ROW_BYTES; i++) m_table[base + i] = m_err_fill;
          n_fills++;
        end else begin
          m_miss[m_cursor] = m_miss[m_cursor] + 5'd1;
        end
        m_ready = 1'b1;
      end
      OP_RESPONSE: begin
        if (c.block_id < TB_BLOCKS) begin
          m_table[base + 0] = nibble_to_pairs(c.byte_first[7:4]);
          m_table[base + 1] = nibble_to_pairs(c.byte_first[3:0]);
          m_table[base + 2] = nibble_to_pairs(c.byte_second[7:4]);
          m_table[base + 3] = nibble_to_pairs(c.byte_second[3:0]);
          m_miss[m_cursor] = '0;
          m_ready = 1'b1;
        end else begin
          n_bad_ids++;
        end
      end
      OP_READ: begin
        n_reads++;
        for (int i = 0; i < TABLE_LEN; i++) begin
          r = '{kind: KIND_TBYTE, code: 2'd0, data: m_table[i], idx: 4'(i),
                last: (i == TABLE_LEN - 1)};
          frame_expect.push_back(r);
        end
        return;
      end
      OP_INIT: begin
        for (int i = 0; i < TABLE_LEN; i++) m_table[i] = m_init_fill;
      end
      default: ;
    endcase
    frame_expect.push_back(r);
  endtask

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 73;
      IDLE_BOTH: return $urandom_range(99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 73;
      IDLE_BOTH: return $urandom_range(99) < 14;
      default:   return 1'b0;
    endcase
  endfunction

  // input driver: presents queued items, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        keeper_step(on_wire);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() != 0 && !sender_gap()) begin
          on_wire = pending.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.op          <= on_wire.op;
          in_ch.block_id    <= on_wire.block_id;
          in_ch.byte_first  <= on_wire.byte_first;
          in_ch.byte_second <= on_wire.byte_second;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off counter, restarted on each change of hold_token
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compares against the oldest expectation, drives ready
  always @(posedge clk) begin
    frame_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (frame_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", out_ch.kind));
        end else begin
          e = frame_expect.pop_front();
          if (out_ch.kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, e.kind));
          if (out_ch.block_code !== e.code)
            report_mismatch($sformatf("block_code %0d, want %0d", out_ch.block_code, e.code));
          if (out_ch.data_byte !== e.data)
            report_mismatch($sformatf("data_byte %0h, want %0h (index %0d)",
                                      out_ch.data_byte, e.data, e.idx));
          if (out_ch.byte_index !== e.idx)
            report_mismatch($sformatf("byte_index %0d, want %0d", out_ch.byte_index, e.idx));
          if (out_ch.last !== e.last)
            report_mismatch($sformatf("last %0b, want %0b", out_ch.last, e.last));
        end
      end
      // long hold-off while the counter runs, otherwise random stalls
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !receiver_stall();
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_telemetry_poll_frame_keeper NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_item(input logic [2:0] op, input logic [7:0] id,
                          input logic [7:0] b1, input logic [7:0] b2);
    poll_cmd_t c;
    c = '{op: op, block_id: id, byte_first: b1, byte_second: b2};
    pending.push_back(c);
    n_queued++;
  endtask

  function automatic logic [7:0] rbyte();
    return 8'($urandom_range(255));
  endfunction

  // mostly poll/answer sequences with random content, some noise
  task automatic queue_random(input int count);
    int target;
    int pick;
    int run;
    target = n_queued + count;
    while (n_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        add_item(OP_POLL, rbyte(), rbyte(), rbyte());
        if ($urandom_range(2) != 0) begin
          add_item(OP_RESPONSE, 8'($urandom_range(TB_BLOCKS - 1)), rbyte(), rbyte());
        end else begin
          run = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
          repeat (run) add_item(OP_TIMEOUT, rbyte(), rbyte(), rbyte());
        end
      end else if (pick < 65) begin
        add_item(OP_READ, rbyte(), rbyte(), rbyte());
      end else if (pick < 72) begin
        add_item(OP_INIT, rbyte(), rbyte(), rbyte());
      end else if (pick < 80) begin
        add_item(OP_RESPONSE, 8'($urandom_range(TB_BLOCKS, 255)), rbyte(), rbyte());
      end else if (pick < 92) begin
        add_item(3'($urandom_range(OP_SPARE_LAST)), rbyte(), rbyte(), rbyte());
      end else begin
        add_item(OP_TIMEOUT, rbyte(), rbyte(), rbyte());
      end
    end
  endtask

  // register write, setup then access phase, while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ERROR_FILL: m_err_fill = value;
      REG_INIT_FILL:  m_init_fill = value;
      REG_MISS_LIMIT: m_limit = value[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [7:0] err_v, input logic [7:0] init_v,
                           input logic [3:0] limit_v);
    write_reg(REG_ERROR_FILL, err_v);
    write_reg(REG_INIT_FILL, init_v);
    write_reg(REG_MISS_LIMIT, {4'd0, limit_v});
  endtask

  // checked at the falling edge so all rising-edge updates have landed
  task automatic wait_drained();
    @(negedge clk);
    while (pending.size() != 0 || in_ch.valid || frame_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input idle_mode_t mode, input int count);
    idle_mode <= mode;
    queue_random(count);
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_POLL;
    in_ch.block_id = '0;
    in_ch.byte_first = '0;
    in_ch.byte_second = '0;
    out_ch.ready = 1'b0;
    keeper_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on reset configuration
    add_item(OP_READ, 8'h00, 8'h00, 8'h00);
    add_item(OP_POLL, 8'hFF, 8'hFF, 8'hFF);         // first poll goes to block 1
    add_item(OP_POLL, 8'h00, 8'h00, 8'h00);         // ready clear: plain ack
    add_item(OP_RESPONSE, 8'd0, 8'h00, 8'hFF);
    add_item(OP_RESPONSE, 8'd3, 8'hA5, 8'h5A);      // data still lands in cursor block
    add_item(OP_RESPONSE, 8'd4, 8'h12, 8'h34);      // id out of range
    add_item(OP_RESPONSE, 8'd255, 8'hFF, 8'h00);
    add_item(OP_POLL, 8'h00, 8'h00, 8'h00);
    repeat (6) add_item(OP_TIMEOUT, 8'h00, 8'h00, 8'h00);  // count past limit, error fill
    add_item(OP_READ, 8'h00, 8'h00, 8'h00);
    add_item(OP_INIT, 8'h00, 8'h00, 8'h00);
    add_item(OP_POLL, 8'h00, 8'h00, 8'h00);
    add_item(OP_TIMEOUT, 8'h00, 8'h00, 8'h00);
    add_item(OP_POLL, 8'h00, 8'h00, 8'h00);         // cursor wraps to block 0
    add_item(OP_SPARE_FIRST, 8'hFF, 8'hFF, 8'hFF);
    add_item(3'd6, 8'h00, 8'h00, 8'h00);
    add_item(OP_SPARE_LAST, 8'h00, 8'h00, 8'h00);
    add_item(OP_READ, 8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    // random phases over the register extremes and random settings
    write_all(8'hFF, 8'h00, 4'd0);
    run_phase(IDLE_NONE, 95);
    write_all(8'h00, 8'hFF, 4'd15);
    run_phase(IDLE_SEND, 95);
    write_all(rbyte(), rbyte(), 4'($urandom_range(15)));
    run_phase(IDLE_RECV, 95);
    write_all(rbyte(), rbyte(), 4'($urandom_range(15)));
    run_phase(IDLE_BOTH, 95);

    // receiver holds off while items keep coming, input must back up
    write_all(rbyte(), rbyte(), 4'($urandom_range(3)));
    idle_mode <= IDLE_NONE;
    hold_token <= hold_token + 1;
    queue_random(30);
    wait_drained();

    if (frame_expect.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_expect.size()));
    $display("run covered %0d items and %0d results: %0d table reads, %0d error fills,",
             n_accepted, n_results, n_reads, n_fills);
    $display("%0d bad-id responses, idle and stall phases plus one long output hold-off",
             n_bad_ids);
    if (err_count == 0) begin
      $display("tb_telemetry_poll_frame_keeper OK");
    end else begin
      $display("tb_telemetry_poll_frame_keeper NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tpfk_pkg.sv
rtl/core/tpfk_if.sv
rtl/core/tpfk_store.sv
rtl/core/telemetry_poll_frame_keeper.sv
tb/sv/tb_telemetry_poll_frame_keeper.sv
